@@ sv/bgr_pkg.sv @@
// ----------------------------------------------------------------------------
// bgr_pkg
// Shared constants and types for the bitmap text glyph renderer.
// ----------------------------------------------------------------------------
package bgr_pkg;

   // default geometry
   localparam int GLYPH_SIZE_DEF  = 32;
   localparam int GLYPH_SLOTS_DEF = 32;

   // character mapping
   localparam logic [7:0] CHAR_A     = 8'h41;
   localparam logic [7:0] CHAR_Z     = 8'h5A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [4:0] SPACE_GLYPH = 5'd26;

   // cursor limit: column must fit 13 bits
   localparam logic [13:0] COL_LIMIT = 14'h1FFF;

   // register reset values
   localparam logic [15:0] LINE_LEN_RST  = 16'd7680;
   localparam logic [13:0] SCR_WIDTH_RST = 14'd1920;
   localparam logic [7:0]  PITCH_RST     = 8'd34;

   // input command codes
   typedef enum logic {
      CMD_LOAD   = 1'b0,
      CMD_RENDER = 1'b1
   } cmd_type;

   // register indexes
   typedef enum logic [2:0] {
      REG_X_OFFSET  = 3'd0,
      REG_Y_OFFSET  = 3'd1,
      REG_LINE_LEN  = 3'd2,
      REG_SCR_WIDTH = 3'd3,
      REG_PITCH     = 3'd4,
      REG_INK       = 3'd5,
      REG_PAPER     = 3'd6
   } reg_idx_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_RUN
   } state_type;

   // control from the sequencer decode
   typedef struct packed {
      logic ready;   // take an input beat
      logic calc;    // compute start address
      logic run;     // stream rows
   } ctrl_type;

endpackage

@@ sv/bgr_ram.sv @@
// ----------------------------------------------------------------------------
// bgr_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bgr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

@@ sv/bitmap_text_glyph_renderer_top.sv @@
// ----------------------------------------------------------------------------
// bitmap_text_glyph_renderer_top
// Glyph store plus text cursor; turns characters into framebuffer row beats.
// ----------------------------------------------------------------------------
// Usage:
//  req channel: one beat per item. tuser is the command (0 load, 1 render).
//    A load beat writes one glyph row into the glyph store.
//    A render beat maps the character to a glyph and streams GLYPH_SIZE rows.
//  rsp channel: one beat per glyph row, carrying the 32 bpp byte address of
//    the row start and its ink mask; tuser flags a bad character, tlast marks
//    the final row of the character.
//  csr channel: register writes, always ready; the user must write only while
//    the block is idle, which the block itself does not enforce. A taken
//    render beat passes address setup, the glyph-store read and the output
//    register before its first row beat, and holds the input side through
//    setup and one read per row. A load item leaves the block idle; the single
//    read port of the glyph store sets the row rate. Stall: when rsp_tready
//    is low the output register and read-data stage hold; no further reads
//    issue until a slot frees. Reset restores the cursor, registers and the
//    sequencer; the glyph store is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module bitmap_text_glyph_renderer_top #(
   parameter int GLYPH_SIZE  = bgr_pkg::GLYPH_SIZE_DEF,
   parameter int GLYPH_SLOTS = bgr_pkg::GLYPH_SLOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_tvalid,
   output logic        req_tready,
   // [4:0] glyph_index, [9:5] glyph_row, [41:10] row_bits, [49:42] char_code
   input  logic [55:0] req_tdata,
   // [0] command
   input  logic        req_tuser,
   // result rows
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [31:0] row_address, [63:32] ink_mask
   output logic [63:0] rsp_tdata,
   // [0] bad_char
   output logic        rsp_tuser,
   output logic        rsp_tlast,
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int DEPTH = GLYPH_SLOTS * GLYPH_SIZE;
   localparam int AW    = $clog2(DEPTH);
   localparam int RW    = $clog2(GLYPH_SIZE);
   localparam logic [RW-1:0] LAST_R = RW'(GLYPH_SIZE - 1);

   // input field split
   logic [4:0]  in_gidx;
   logic [4:0]  in_grow;
   logic [31:0] in_bits;
   logic [7:0]  in_code;
   assign in_gidx = req_tdata[4:0];
   assign in_grow = req_tdata[9:5];
   assign in_bits = req_tdata[41:10];
   assign in_code = req_tdata[49:42];

   // configuration registers
   logic [15:0] x_off_ff, y_off_ff, line_len_ff;
   logic [13:0] scr_width_ff;
   logic [7:0]  pitch_ff;

   // cursor
   logic [12:0] cur_col_ff, cur_col_in;
   logic [15:0] cur_row_ff, cur_row_in;

   // sequencer
   bgr_pkg::state_type state_ff, state_in;
   bgr_pkg::ctrl_type  ctrl;
   logic [RW-1:0]      r_ff, r_in;
   logic [AW-1:0]      gbase_ff, gbase_in;
   logic               bad_ff, bad_in;
   logic [31:0]        addr_ff, addr_in;

   // read-data stage (data sits in the RAM output register)
   logic        p_vld_ff, p_vld_in;
   logic [31:0] p_addr_ff, p_addr_in;
   logic        p_bad_ff, p_bad_in;
   logic        p_last_ff, p_last_in;

   // output register
   logic        o_vld_ff, o_vld_in;
   logic [31:0] o_addr_ff, o_addr_in;
   logic [31:0] o_mask_ff, o_mask_in;
   logic        o_bad_ff, o_bad_in;
   logic        o_last_ff, o_last_in;

   logic                  accept, is_render, is_load;
   logic                  issue, move;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic [GLYPH_SIZE-1:0] rd_data;
   logic [31:0]           mask_ext;
   logic [4:0]            glyph;
   logic                  bad_code;
   logic [13:0]           col_next;
   logic [16:0]           xsum, ysum;
   logic [32:0]           yprod;

   assign accept    = req_tvalid && req_tready;
   assign is_render = (req_tuser == bgr_pkg::CMD_RENDER);
   assign is_load   = (req_tuser == bgr_pkg::CMD_LOAD);

   // ---------------- configuration ----------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_off_ff     <= '0;
         y_off_ff     <= '0;
         line_len_ff  <= bgr_pkg::LINE_LEN_RST;
         scr_width_ff <= bgr_pkg::SCR_WIDTH_RST;
         pitch_ff     <= bgr_pkg::PITCH_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bgr_pkg::REG_X_OFFSET:  x_off_ff     <= csr_data;
            bgr_pkg::REG_Y_OFFSET:  y_off_ff     <= csr_data;
            bgr_pkg::REG_LINE_LEN:  line_len_ff  <= csr_data;
            bgr_pkg::REG_SCR_WIDTH: scr_width_ff <= csr_data[13:0];
            bgr_pkg::REG_PITCH:     pitch_ff     <= csr_data[7:0];
            // color level writes are accepted and ignored here
            bgr_pkg::REG_INK, bgr_pkg::REG_PAPER: ;
            default: ;
         endcase
      end
   end

   // ---------------- character decode ----------------
   always_comb begin
      if (in_code >= bgr_pkg::CHAR_A && in_code <= bgr_pkg::CHAR_Z) begin
         glyph    = 5'(in_code - bgr_pkg::CHAR_A);
         bad_code = 1'b0;
      end else begin
         glyph    = bgr_pkg::SPACE_GLYPH;
         bad_code = (in_code != bgr_pkg::CHAR_SPACE);
      end
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bgr_pkg::ST_IDLE: begin
            if (accept && is_render) begin
               state_in = bgr_pkg::ST_CALC;
            end
         end
         bgr_pkg::ST_CALC: state_in = bgr_pkg::ST_RUN;
         bgr_pkg::ST_RUN: begin
            if (issue && r_ff == LAST_R) begin
               state_in = bgr_pkg::ST_IDLE;
            end
         end
         default: state_in = bgr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl = '0;
      unique case (state_ff)
         bgr_pkg::ST_IDLE: ctrl.ready = 1'b1;
         bgr_pkg::ST_CALC: ctrl.calc  = 1'b1;
         bgr_pkg::ST_RUN:  ctrl.run   = 1'b1;
         default:          ctrl       = '0;
      endcase
   end

   assign req_tready = ctrl.ready;

   // a read may issue when the read-data stage is empty or drains this cycle
   assign move  = p_vld_ff && (!o_vld_ff || rsp_tready);
   assign issue = ctrl.run && (!p_vld_ff || move);

   // start address: (col + x_off) * 4 + (row + y_off) * line_len, mod 2^32
   assign xsum     = 17'(cur_col_ff) + 17'(x_off_ff);
   assign ysum     = 17'(cur_row_ff) + 17'(y_off_ff);
   assign yprod    = ysum * line_len_ff;
   assign col_next = 14'(cur_col_ff) + 14'(GLYPH_SIZE);

   always_comb begin
      r_in       = r_ff;
      gbase_in   = gbase_ff;
      bad_in     = bad_ff;
      addr_in    = addr_ff;
      cur_col_in = cur_col_ff;
      cur_row_in = cur_row_ff;
      if (accept && is_render) begin
         gbase_in = AW'(32'(glyph) * GLYPH_SIZE);
         bad_in   = bad_code;
      end
      if (ctrl.calc) begin
         r_in    = '0;
         addr_in = {13'd0, xsum, 2'b00} + yprod[31:0];
      end
      if (issue) begin
         r_in    = r_ff + 1'b1;
         addr_in = addr_ff + 32'(line_len_ff);
         if (r_ff == LAST_R) begin
            // cursor moves once the last row is under way
            if (col_next >= scr_width_ff || col_next > bgr_pkg::COL_LIMIT) begin
               cur_col_in = '0;
               cur_row_in = cur_row_ff + 16'(pitch_ff);
            end else begin
               cur_col_in = col_next[12:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= bgr_pkg::ST_IDLE;
         cur_col_ff <= '0;
         cur_row_ff <= '0;
         r_ff       <= '0;
      end else begin
         state_ff   <= state_in;
         cur_col_ff <= cur_col_in;
         cur_row_ff <= cur_row_in;
         r_ff       <= r_in;
      end
   end

   always_ff @(posedge clock) begin
      gbase_ff <= gbase_in;
      bad_ff   <= bad_in;
      addr_ff  <= addr_in;
   end

   // ---------------- glyph store ----------------
   assign wr_en   = accept && is_load && (32'(in_gidx) < GLYPH_SLOTS)
                    && (32'(in_grow) < GLYPH_SIZE);
   assign wr_addr = AW'(32'(in_gidx) * GLYPH_SIZE + 32'(in_grow));
   assign rd_addr = gbase_ff + AW'(r_ff);

   bgr_ram #(
      .WIDTH (GLYPH_SIZE),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (in_bits[GLYPH_SIZE-1:0]),
      .rd_en   (issue),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // ---------------- read-data and output stages ----------------
   always_comb begin
      mask_ext = '0;
      mask_ext[GLYPH_SIZE-1:0] = rd_data;
   end

   always_comb begin
      p_vld_in  = p_vld_ff;
      p_addr_in = p_addr_ff;
      p_bad_in  = p_bad_ff;
      p_last_in = p_last_ff;
      if (issue) begin
         p_vld_in  = 1'b1;
         p_addr_in = addr_ff;
         p_bad_in  = bad_ff;
         p_last_in = (r_ff == LAST_R);
      end else if (move) begin
         p_vld_in = 1'b0;
      end
   end

   always_comb begin
      o_vld_in  = o_vld_ff;
      o_addr_in = o_addr_ff;
      o_mask_in = o_mask_ff;
      o_bad_in  = o_bad_ff;
      o_last_in = o_last_ff;
      if (move) begin
         o_vld_in  = 1'b1;
         o_addr_in = p_addr_ff;
         o_mask_in = mask_ext;
         o_bad_in  = p_bad_ff;
         o_last_in = p_last_ff;
      end else if (rsp_tready) begin
         o_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff <= 1'b0;
         o_vld_ff <= 1'b0;
      end else begin
         p_vld_ff <= p_vld_in;
         o_vld_ff <= o_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      p_addr_ff <= p_addr_in;
      p_bad_ff  <= p_bad_in;
      p_last_ff <= p_last_in;
      o_addr_ff <= o_addr_in;
      o_mask_ff <= o_mask_in;
      o_bad_ff  <= o_bad_in;
      o_last_ff <= o_last_in;
   end

   assign rsp_tvalid = o_vld_ff;
   assign rsp_tdata  = {o_mask_ff, o_addr_ff};
   assign rsp_tuser  = o_bad_ff;
   assign rsp_tlast  = o_last_ff;

`ifndef ASSERT_OFF
   // held read data must not be overwritten by a new read
   a_no_clobber: assert property (@(posedge clock) disable iff (reset)
      p_vld_ff && !move |-> !issue)
      else $error("glyph read issued over held row");

   // a taken render beat starts address setup
   a_render_start: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == bgr_pkg::CMD_RENDER
      |=> state_ff == bgr_pkg::ST_CALC)
      else $error("render beat did not start setup");

   // row counter restarts for every character
   a_row_restart: assert property (@(posedge clock) disable iff (reset)
      state_ff == bgr_pkg::ST_CALC |=> r_ff == '0)
      else $error("row counter not cleared");

   // last row read returns the sequencer to idle
   a_last_exit: assert property (@(posedge clock) disable iff (reset)
      issue && r_ff == LAST_R |=> state_ff == bgr_pkg::ST_IDLE)
      else $error("sequencer kept running past last row");
`endif

endmodule
